FILE: sv/swif_pkg.sv
package swif_pkg;

  localparam int WORD_BITS = 32;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef struct packed {
    word_t left_density;
    word_t left_momentum;
    word_t left_energy;
    word_t right_density;
    word_t right_momentum;
    word_t right_energy;
  } in_t;

  typedef struct packed {
    word_t flux_mass;
    word_t flux_momentum;
    word_t flux_energy;
    logic  bad_state;
  } out_t;

  typedef struct packed {
    word_t f_mass;
    word_t f_mom;
    word_t f_energy;
    logic  bad;
  } side_t;

  localparam word_t W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  function automatic word_t sat_add(word_t a, word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return s[WORD_BITS] ? W_MIN : W_MAX;
    end
    return s[WORD_BITS-1:0];
  endfunction

  function automatic word_t sat_sub(word_t a, word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return s[WORD_BITS] ? W_MIN : W_MAX;
    end
    return s[WORD_BITS-1:0];
  endfunction

  // divider: entry + one stage per quotient bit + round; root: same per root bit
  function automatic int side_lat(int frac);
    int ld;
    int ls;
    ld = WORD_BITS + frac + 2;
    ls = ((WORD_BITS + frac + 1) >> 1) + 2;
    return 2 * ld + ls + 22;
  endfunction

endpackage

FILE: sv/swif_dly.sv
module swif_dly #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] sr_r [DEPTH];

  always_ff @(posedge clk) begin
    sr_r[0] <= d;
    for (int i = 1; i < DEPTH; i++) begin
      sr_r[i] <= sr_r[i-1];
    end
  end

  assign q = sr_r[DEPTH-1];

endmodule

FILE: sv/swif_mul.sv
module swif_mul #(
  parameter int FRACTION_BITS = 24
) (
  input  logic            clk,
  input  swif_pkg::word_t a,
  input  swif_pkg::word_t b,
  output swif_pkg::word_t y
);

  localparam int W  = swif_pkg::WORD_BITS;
  localparam int PW = 2 * W;
  localparam logic [PW:0] RND  = (PW+1)'(1) << (FRACTION_BITS - 1);
  localparam logic [PW:0] LIMN = (PW+1)'(1) << (W - 1);
  localparam logic [PW:0] LIMP = LIMN - (PW+1)'(1);

  logic [W-1:0]  ma;
  logic [W-1:0]  mb;
  logic [PW-1:0] pm_r;
  logic          neg_r;
  logic [PW:0]   rs;
  logic [PW:0]   qs;
  logic [PW:0]   lim;
  logic [PW:0]   qc;
  logic [PW:0]   qn;
  swif_pkg::word_t y_r;

  assign ma = a[W-1] ? (~a + 1'b1) : a;
  assign mb = b[W-1] ? (~b + 1'b1) : b;

  always_ff @(posedge clk) begin
    pm_r  <= PW'(ma) * PW'(mb);
    neg_r <= a[W-1] ^ b[W-1];
  end

  always_comb begin
    rs  = {1'b0, pm_r} + RND;
    qs  = rs >> FRACTION_BITS;
    lim = neg_r ? LIMN : LIMP;
    qc  = (qs > lim) ? lim : qs;
    qn  = ~qc + 1'b1;
  end

  always_ff @(posedge clk) begin
    y_r <= neg_r ? qn[W-1:0] : qc[W-1:0];
  end

  assign y = y_r;

endmodule

FILE: sv/swif_div.sv
module swif_div #(
  parameter int FRACTION_BITS = 24
) (
  input  logic            clk,
  input  swif_pkg::word_t a,
  input  swif_pkg::word_t b,
  output swif_pkg::word_t y
);

  localparam int W  = swif_pkg::WORD_BITS;
  localparam int NB = W + FRACTION_BITS;
  localparam logic [NB:0] LIMN = (NB+1)'(1) << (W - 1);
  localparam logic [NB:0] LIMP = LIMN - (NB+1)'(1);

  logic [W-1:0]    ua;
  logic [W-1:0]    ub;
  swif_pkg::word_t sv;

  logic [W-1:0]    rem_r [NB+1];
  logic [NB-1:0]   nq_r  [NB+1];
  logic [W-1:0]    ub_r  [NB+1];
  logic            neg_r [NB+1];
  logic            zb_r  [NB+1];
  swif_pkg::word_t sv_r  [NB+1];

  logic [W-1:0]    rem_n [NB];
  logic [NB-1:0]   nq_n  [NB];

  logic [NB:0]     qq;
  logic [NB:0]     lim;
  logic [NB:0]     qc;
  logic [NB:0]     qn;
  logic            rnd;
  swif_pkg::word_t y_r;

  assign ua = a[W-1] ? (~a + 1'b1) : a;
  assign ub = b[W-1] ? (~b + 1'b1) : b;
  assign sv = (a == '0) ? '0 : (a[W-1] ? swif_pkg::W_MIN : swif_pkg::W_MAX);

  always_comb begin
    for (int k = 0; k < NB; k++) begin
      logic [W:0] rr;
      rr = {rem_r[k], nq_r[k][NB-1]};
      if (rr >= {1'b0, ub_r[k]}) begin
        rem_n[k] = W'(rr - {1'b0, ub_r[k]});
        nq_n[k]  = {nq_r[k][NB-2:0], 1'b1};
      end else begin
        rem_n[k] = rr[W-1:0];
        nq_n[k]  = {nq_r[k][NB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= '0;
    nq_r[0]  <= {ua, {FRACTION_BITS{1'b0}}};
    ub_r[0]  <= ub;
    neg_r[0] <= a[W-1] ^ b[W-1];
    zb_r[0]  <= (ub == '0);
    sv_r[0]  <= sv;
    for (int k = 0; k < NB; k++) begin
      rem_r[k+1] <= rem_n[k];
      nq_r[k+1]  <= nq_n[k];
      ub_r[k+1]  <= ub_r[k];
      neg_r[k+1] <= neg_r[k];
      zb_r[k+1]  <= zb_r[k];
      sv_r[k+1]  <= sv_r[k];
    end
  end

  always_comb begin
    rnd = ({rem_r[NB], 1'b0} >= {1'b0, ub_r[NB]});
    qq  = {1'b0, nq_r[NB]} + (NB+1)'(rnd);
    lim = neg_r[NB] ? LIMN : LIMP;
    qc  = (qq > lim) ? lim : qq;
    qn  = ~qc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (zb_r[NB]) begin
      y_r <= sv_r[NB];
    end else begin
      y_r <= neg_r[NB] ? qn[W-1:0] : qc[W-1:0];
    end
  end

  assign y = y_r;

endmodule

FILE: sv/swif_sqrt.sv
module swif_sqrt #(
  parameter int FRACTION_BITS = 24
) (
  input  logic            clk,
  input  swif_pkg::word_t x,
  output swif_pkg::word_t y
);

  localparam int W  = swif_pkg::WORD_BITS;
  localparam int RB = (W + FRACTION_BITS + 1) / 2;
  localparam int XB = 2 * RB;
  localparam int RW = RB + 2;

  logic [W-1:0]    ux;
  logic [RW-1:0]   rm_r [RB+1];
  logic [XB-1:0]   xs_r [RB+1];
  logic [RB-1:0]   rt_r [RB+1];
  logic [RW-1:0]   rm_n [RB];
  logic [RB-1:0]   rt_n [RB];
  logic [RB+W-1:0] rx;
  logic [RB+W-1:0] lim;
  swif_pkg::word_t y_r;

  assign ux = x[W-1] ? '0 : x;

  always_comb begin
    for (int k = 0; k < RB; k++) begin
      logic [RW+1:0] sh;
      logic [RW+1:0] tr;
      sh = {rm_r[k], xs_r[k][XB-1:XB-2]};
      tr = (RW+2)'({rt_r[k], 2'b01});
      if (sh >= tr) begin
        rm_n[k] = RW'(sh - tr);
        rt_n[k] = {rt_r[k][RB-2:0], 1'b1};
      end else begin
        rm_n[k] = sh[RW-1:0];
        rt_n[k] = {rt_r[k][RB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    rm_r[0] <= '0;
    xs_r[0] <= XB'({ux, {FRACTION_BITS{1'b0}}});
    rt_r[0] <= '0;
    for (int k = 0; k < RB; k++) begin
      rm_r[k+1] <= rm_n[k];
      xs_r[k+1] <= xs_r[k] << 2;
      rt_r[k+1] <= rt_n[k];
    end
  end

  assign rx  = (RB+W)'(rt_r[RB]);
  assign lim = (RB+W)'(swif_pkg::W_MAX);

  always_ff @(posedge clk) begin
    y_r <= (rx > lim) ? swif_pkg::W_MAX : rx[W-1:0];
  end

  assign y = y_r;

endmodule

FILE: sv/swif_side.sv
module swif_side #(
  parameter int FRACTION_BITS = 24,
  parameter bit POSITIVE      = 1'b1
) (
  input  logic            clk,
  input  swif_pkg::word_t rho,
  input  swif_pkg::word_t mom,
  input  swif_pkg::word_t en,
  output swif_pkg::side_t res
);

  localparam int W  = swif_pkg::WORD_BITS;
  localparam int LD = W + FRACTION_BITS + 2;
  localparam int LS = ((W + FRACTION_BITS + 1) / 2) + 2;
  localparam longint KONE = longint'(1) << FRACTION_BITS;
  localparam swif_pkg::word_t K_HALF  = W'(KONE >>> 1);
  localparam swif_pkg::word_t K_GM1   = W'((2 * KONE + 2) / 5);
  localparam swif_pkg::word_t K_GM1X2 = W'((4 * KONE + 2) / 5);
  localparam swif_pkg::word_t K_GAMMA = W'((7 * KONE + 2) / 5);
  localparam swif_pkg::word_t K_INV2G = W'((5 * KONE + 7) / 14);

  function automatic swif_pkg::word_t eig(swif_pkg::word_t v);
    if (POSITIVE) begin
      return (!v[W-1] && v != '0) ? v : '0;
    end
    return v[W-1] ? v : '0;
  endfunction

  typedef swif_pkg::word_t word_t;

  // primitive variables
  word_t u, mom_d, m1, m2, en_d, dd_r, p, gp, rho_d1, a2, a;
  logic  rho_bad, rb_d, bad1, bad_d;
  word_t u_d3, a2_d3, rho_d3;

  assign rho_bad = rho[W-1] | (rho == '0);

  swif_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (.clk, .a(mom), .b(rho), .y(u));
  swif_dly #(.WIDTH(W), .DEPTH(LD)) d_mom (.clk, .d(mom), .q(mom_d));
  swif_mul #(.FRACTION_BITS(FRACTION_BITS)) u_m1 (.clk, .a(mom_d), .b(u), .y(m1));
  swif_mul #(.FRACTION_BITS(FRACTION_BITS)) u_m2 (.clk, .a(m1), .b(K_HALF), .y(m2));
  swif_dly #(.WIDTH(W), .DEPTH(LD+4)) d_en (.clk, .d(en), .q(en_d));

  always_ff @(posedge clk) begin
    dd_r <= swif_pkg::sat_sub(en_d, m2);
  end

  swif_mul #(.FRACTION_BITS(FRACTION_BITS)) u_p (.clk, .a(dd_r), .b(K_GM1), .y(p));
  swif_mul #(.FRACTION_BITS(FRACTION_BITS)) u_gp (.clk, .a(K_GAMMA), .b(p), .y(gp));
  swif_dly #(.WIDTH(W), .DEPTH(LD+9)) d_rho1 (.clk, .d(rho), .q(rho_d1));
  swif_div #(.FRACTION_BITS(FRACTION_BITS)) a2_div (.clk, .a(gp), .b(rho_d1), .y(a2));
  swif_sqrt #(.FRACTION_BITS(FRACTION_BITS)) a_sqrt (.clk, .x(a2), .y(a));

  swif_dly #(.WIDTH(1), .DEPTH(LD+7)) d_rb (.clk, .d(rho_bad), .q(rb_d));
  assign bad1 = rb_d | p[W-1] | (p == '0);
  swif_dly #(.WIDTH(1), .DEPTH(LD+LS+15)) d_bad (.clk, .d(bad1), .q(bad_d));

  swif_dly #(.WIDTH(W), .DEPTH(LD+9+LS)) d_u3 (.clk, .d(u), .q(u_d3));
  swif_dly #(.WIDTH(W), .DEPTH(LS)) d_a23 (.clk, .d(a2), .q(a2_d3));
  swif_dly #(.WIDTH(W), .DEPTH(LD+LS)) d_rho3 (.clk, .d(rho_d1), .q(rho_d3));

  // eigenvalue split
  word_t upa_r, uma_r, u1_r, a2_1_r, rho1_r;
  word_t l1_r, l2_r, l3_r, s23_r, u2_r, upa2_r, uma2_r, a2_2_r, rho2_r;

  always_ff @(posedge clk) begin
    upa_r  <= swif_pkg::sat_add(u_d3, a);
    uma_r  <= swif_pkg::sat_sub(u_d3, a);
    u1_r   <= u_d3;
    a2_1_r <= a2_d3;
    rho1_r <= rho_d3;
    l1_r   <= eig(u1_r);
    l2_r   <= eig(upa_r);
    l3_r   <= eig(uma_r);
    s23_r  <= swif_pkg::sat_add(eig(upa_r), eig(uma_r));
    u2_r   <= u1_r;
    upa2_r <= upa_r;
    uma2_r <= uma_r;
    a2_2_r <= a2_1_r;
    rho2_r <= rho1_r;
  end

  // first product level
  word_t g1, p2, p3, qa, qb, gl, uu, ts, fac;
  word_t l2_4, l3_4, u_4;

  swif_mul #(.FRACTION_BITS(FRACTION_BITS)) u_g1 (.clk, .a(K_GM1X2), .b(l1_r), .y(g1));
  swif_mul #(.FRACTION_BITS(FRACTION_BITS)) u_p2 (.clk, .a(l2_r), .b(upa2_r), .y(p2));
  swif_mul #(.FRACTION_BITS(FRACTION_BITS)) u_p3 (.clk, .a(l3_r), .b(uma2_r), .y(p3));
  swif_mul #(.FRACTION_BITS(FRACTION_BITS)) u_qa (.clk, .a(upa2_r), .b(upa2_r), .y(qa));
  swif_mul #(.FRACTION_BITS(FRACTION_BITS)) u_qb (.clk, .a(uma2_r), .b(uma2_r), .y(qb));
  swif_mul #(.FRACTION_BITS(FRACTION_BITS)) u_gl (.clk, .a(K_GM1), .b(l1_r), .y(gl));
  swif_mul #(.FRACTION_BITS(FRACTION_BITS)) u_uu (.clk, .a(u2_r), .b(u2_r), .y(uu));
  swif_mul #(.FRACTION_BITS(FRACTION_BITS)) u_ts (.clk, .a(s23_r), .b(a2_2_r), .y(ts));
  swif_mul #(.FRACTION_BITS(FRACTION_BITS)) u_fac (.clk, .a(rho2_r), .b(K_INV2G), .y(fac));
  swif_dly #(.WIDTH(W), .DEPTH(2)) d_l2 (.clk, .d(l2_r), .q(l2_4));
  swif_dly #(.WIDTH(W), .DEPTH(2)) d_l3 (.clk, .d(l3_r), .q(l3_4));
  swif_dly #(.WIDTH(W), .DEPTH(2)) d_u4 (.clk, .d(u2_r), .q(u_4));

  // second product level and bracket sums
  word_t g1u, l2q, l3q, glu, p2_6, p3_6;
  word_t c0a_r, ts2_r, l3_5_r, c0_r;

  swif_mul #(.FRACTION_BITS(FRACTION_BITS)) u_g1u (.clk, .a(g1), .b(u_4), .y(g1u));
  swif_mul #(.FRACTION_BITS(FRACTION_BITS)) u_l2q (.clk, .a(l2_4), .b(qa), .y(l2q));
  swif_mul #(.FRACTION_BITS(FRACTION_BITS)) u_l3q (.clk, .a(l3_4), .b(qb), .y(l3q));
  swif_mul #(.FRACTION_BITS(FRACTION_BITS)) u_glu (.clk, .a(gl), .b(uu), .y(glu));
  swif_dly #(.WIDTH(W), .DEPTH(2)) d_p2 (.clk, .d(p2), .q(p2_6));
  swif_dly #(.WIDTH(W), .DEPTH(2)) d_p3 (.clk, .d(p3), .q(p3_6));

  word_t c1a_r, p3_7_r, c1_r, tq_r, hq, glu_9, ts2_10, c2a_r, c2_r;

  always_ff @(posedge clk) begin
    c0a_r  <= swif_pkg::sat_add(g1, l2_4);
    l3_5_r <= l3_4;
    ts2_r  <= swif_pkg::sat_add(ts, ts);
    c0_r   <= swif_pkg::sat_add(c0a_r, l3_5_r);
    c1a_r  <= swif_pkg::sat_add(g1u, p2_6);
    p3_7_r <= p3_6;
    c1_r   <= swif_pkg::sat_add(c1a_r, p3_7_r);
    tq_r   <= swif_pkg::sat_add(l2q, l3q);
    c2a_r  <= swif_pkg::sat_add(glu_9, hq);
    c2_r   <= swif_pkg::sat_add(c2a_r, ts2_10);
  end

  swif_mul #(.FRACTION_BITS(FRACTION_BITS)) u_hq (.clk, .a(K_HALF), .b(tq_r), .y(hq));
  swif_dly #(.WIDTH(W), .DEPTH(3)) d_glu (.clk, .d(glu), .q(glu_9));
  swif_dly #(.WIDTH(W), .DEPTH(5)) d_ts2 (.clk, .d(ts2_r), .q(ts2_10));

  // density scale
  word_t c0_11, c1_11, fac_11, f0, f1, f2;

  swif_dly #(.WIDTH(W), .DEPTH(5)) d_c0 (.clk, .d(c0_r), .q(c0_11));
  swif_dly #(.WIDTH(W), .DEPTH(3)) d_c1 (.clk, .d(c1_r), .q(c1_11));
  swif_dly #(.WIDTH(W), .DEPTH(7)) d_fac (.clk, .d(fac), .q(fac_11));
  swif_mul #(.FRACTION_BITS(FRACTION_BITS)) u_f0 (.clk, .a(fac_11), .b(c0_11), .y(f0));
  swif_mul #(.FRACTION_BITS(FRACTION_BITS)) u_f1 (.clk, .a(fac_11), .b(c1_11), .y(f1));
  swif_mul #(.FRACTION_BITS(FRACTION_BITS)) u_f2 (.clk, .a(fac_11), .b(c2_r), .y(f2));

  assign res = '{f_mass: f0, f_mom: f1, f_energy: f2, bad: bad_d};

endmodule

FILE: sv/steger_warming_interface_flux_core.sv
// Steger-Warming interface flux, 1D Euler, gamma 1.4, signed fixed point.
// Input: one interface word (left and right conserved states) is taken
// on each clock edge where start is high and busy is low. busy never rises:
// a new word may be given every cycle.
// Output: out_valid strobes for one cycle with out_data holding the mass,
// momentum and energy flux, saturated, and bad_state. When bad_state is set
// (density or pressure not positive on a side) the fluxes read zero.
// The data path runs through the two bit-per-stage dividers (velocity, then
// sound speed squared) and the bit-per-stage square root, all in series.
// Throughput: one word per cycle; every unit is fully pipelined.
// Reset clears the valid pipeline, so no strobe follows reset until a word
// is taken. The receiver must take each result in its strobe cycle.
module steger_warming_interface_flux_core #(
  parameter int FRACTION_BITS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  swif_pkg::in_t     in_data,
  output logic              out_valid,
  output swif_pkg::out_t    out_data
);

  localparam int LAT = swif_pkg::side_lat(FRACTION_BITS) + 1;

  logic            acc;
  logic [LAT-1:0]  vld_r;
  swif_pkg::side_t lres;
  swif_pkg::side_t rres;
  swif_pkg::out_t  out_r;
  swif_pkg::out_t  out_nxt;

  assign busy = 1'b0;
  assign acc  = start & ~busy;

  swif_side #(.FRACTION_BITS(FRACTION_BITS), .POSITIVE(1'b1)) u_left (
    .clk,
    .rho (in_data.left_density),
    .mom (in_data.left_momentum),
    .en  (in_data.left_energy),
    .res (lres)
  );

  swif_side #(.FRACTION_BITS(FRACTION_BITS), .POSITIVE(1'b0)) u_right (
    .clk,
    .rho (in_data.right_density),
    .mom (in_data.right_momentum),
    .en  (in_data.right_energy),
    .res (rres)
  );

  always_comb begin
    if (lres.bad | rres.bad) begin
      out_nxt = '{flux_mass: '0, flux_momentum: '0, flux_energy: '0, bad_state: 1'b1};
    end else begin
      out_nxt.flux_mass     = swif_pkg::sat_add(lres.f_mass, rres.f_mass);
      out_nxt.flux_momentum = swif_pkg::sat_add(lres.f_mom, rres.f_mom);
      out_nxt.flux_energy   = swif_pkg::sat_add(lres.f_energy, rres.f_energy);
      out_nxt.bad_state     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], acc};
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = vld_r[LAT-1];
  assign out_data  = out_r;

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_state |->
      out_data.flux_mass == '0 && out_data.flux_momentum == '0 &&
      out_data.flux_energy == '0)
    else $error("bad_state word carries nonzero flux");

  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LAT out_valid)
    else $error("accepted word produced no strobe");

  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("strobe without matching accepted word");

endmodule
